[src/c_comment_stripper_unit_macros.svh]
// assertion macros used by the checker file
`ifndef C_COMMENT_STRIPPER_UNIT_MACROS_SVH
`define C_COMMENT_STRIPPER_UNIT_MACROS_SVH

// same-cycle implication, off while reset is high
`define CCS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccs check failed");

// next-cycle implication, off while reset is high
`define CCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ccs check failed");

// next-cycle implication that also holds across reset
`define CCS_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ccs check failed");

`endif

[src/ccs_pkg.sv]
// types and character constants for the comment stripper
`default_nettype none

package ccs_pkg;

  typedef enum logic [3:0] {
    MODE_NORMAL   = 4'd0,
    MODE_SLASH    = 4'd1,
    MODE_LINE     = 4'd2,
    MODE_LINE_BS  = 4'd3,
    MODE_BLOCK    = 4'd4,
    MODE_BLOCK_ST = 4'd5,
    MODE_DQ       = 4'd6,
    MODE_DQ_ESC   = 4'd7,
    MODE_SQ       = 4'd8,
    MODE_SQ_ESC   = 4'd9
  } ccs_mode_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  // one queued request: one or two output bytes
  typedef struct packed {
    logic       two;
    logic [7:0] c0;
    logic [7:0] c1;
    logic       done;
  } ccs_entry_t;

endpackage

`default_nettype wire

[src/ccs_front.sv]
// lexer front end: tracks the comment/string mode and classifies each byte
`default_nettype none

module ccs_front (
  input  wire              clk,
  input  wire              rst,
  input  wire              char_valid,
  output logic             char_stall,
  input  wire  [7:0]       in_char,
  input  wire              end_of_stream,
  input  wire              queue_full,
  output logic             push,
  output ccs_pkg::ccs_entry_t push_entry
);
  import ccs_pkg::*;

  ccs_mode_t  mode;
  ccs_mode_t  mode_next;
  logic [1:0] nres;
  logic       accept;

  assign char_stall = queue_full;
  assign accept     = char_valid && !queue_full;
  assign push       = accept && (nres != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

  always_comb begin
    nres            = 2'd0;
    mode_next       = mode;
    push_entry.two  = 1'b0;
    push_entry.c0   = in_char;
    push_entry.c1   = CH_NUL;
    push_entry.done = 1'b0;
    if (end_of_stream) begin
      // flush a held slash ahead of the end marker
      if (mode == MODE_SLASH) begin
        nres            = 2'd2;
        push_entry.two  = 1'b1;
        push_entry.c0   = CH_SLASH;
      end else begin
        nres            = 2'd1;
        push_entry.c0   = CH_NUL;
      end
      push_entry.done = 1'b1;
      mode_next       = MODE_NORMAL;
    end else if (in_char != CH_CR) begin
      case (mode)
        MODE_SLASH: begin
          if (in_char == CH_SLASH) begin
            mode_next = MODE_LINE;
          end else if (in_char == CH_STAR) begin
            mode_next = MODE_BLOCK;
          end else begin
            // held slash was not a comment start
            nres           = 2'd2;
            push_entry.two = 1'b1;
            push_entry.c0  = CH_SLASH;
            push_entry.c1  = in_char;
            if (in_char == CH_DQ) begin
              mode_next = MODE_DQ;
            end else if (in_char == CH_SQ) begin
              mode_next = MODE_SQ;
            end else begin
              mode_next = MODE_NORMAL;
            end
          end
        end
        MODE_LINE: begin
          if (in_char == CH_NL) begin
            nres      = 2'd1;
            mode_next = MODE_NORMAL;
          end else if (in_char == CH_BSL) begin
            mode_next = MODE_LINE_BS;
          end
        end
        MODE_LINE_BS: begin
          mode_next = (in_char == CH_BSL) ? MODE_LINE_BS : MODE_LINE;
        end
        MODE_BLOCK: begin
          if (in_char == CH_STAR) begin
            mode_next = MODE_BLOCK_ST;
          end else if (in_char == CH_NL) begin
            nres = 2'd1;
          end
        end
        MODE_BLOCK_ST: begin
          if (in_char == CH_SLASH) begin
            mode_next = MODE_NORMAL;
          end else if (in_char != CH_STAR) begin
            if (in_char == CH_NL) begin
              nres = 2'd1;
            end
            mode_next = MODE_BLOCK;
          end
        end
        MODE_DQ: begin
          nres = 2'd1;
          if (in_char == CH_BSL) begin
            mode_next = MODE_DQ_ESC;
          end else if (in_char == CH_DQ || in_char == CH_NL) begin
            mode_next = MODE_NORMAL;
          end
        end
        MODE_SQ: begin
          nres = 2'd1;
          if (in_char == CH_BSL) begin
            mode_next = MODE_SQ_ESC;
          end else if (in_char == CH_SQ || in_char == CH_NL) begin
            mode_next = MODE_NORMAL;
          end
        end
        MODE_DQ_ESC: begin
          nres      = 2'd1;
          mode_next = MODE_DQ;
        end
        MODE_SQ_ESC: begin
          nres      = 2'd1;
          mode_next = MODE_SQ;
        end
        default: begin
          // normal code, unused codes included
          if (in_char == CH_SLASH) begin
            mode_next = MODE_SLASH;
          end else begin
            nres = 2'd1;
            if (in_char == CH_DQ) begin
              mode_next = MODE_DQ;
            end else if (in_char == CH_SQ) begin
              mode_next = MODE_SQ;
            end else begin
              mode_next = MODE_NORMAL;
            end
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/ccs_queue.sv]
// small queue of classified requests between front end and output stage
`default_nettype none

module ccs_queue #(
  parameter int Depth = 4
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  ccs_pkg::ccs_entry_t push_entry,
  output logic                full,
  input  wire                 pop,
  output logic                head_valid,
  output ccs_pkg::ccs_entry_t head
);
  import ccs_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ccs_entry_t          store [Depth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;

  assign full       = (count == FullCnt);
  assign head_valid = (count != '0);
  assign head       = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[src/ccs_back.sv]
// output stage: unpacks queued requests into single bytes in a result register
`default_nettype none

module ccs_back (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 head_valid,
  input  ccs_pkg::ccs_entry_t head,
  output logic                pop,
  output logic                result_valid,
  input  wire                 result_stall,
  output logic [7:0]          out_char,
  output logic                stream_done,
  output logic                last
);
  import ccs_pkg::*;

  logic load;
  logic phase;   // first byte of a two-byte request already sent
  logic final_byte;

  assign load       = head_valid && (!result_valid || !result_stall);
  assign final_byte = !head.two || phase;
  assign pop        = load && final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      phase        <= 1'b0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        phase        <= !final_byte;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char    <= phase ? head.c1 : head.c0;
      stream_done <= head.done && final_byte;
      last        <= final_byte;
    end
  end

endmodule

`default_nettype wire

[src/c_comment_stripper_unit.sv]
// a byte with results is queued as a request, then loaded into the result register
// throughput: one input byte per cycle while the request queue is not full; a byte
//   with two results gives two output bytes, and the queue absorbs the difference
// a byte that yields no result (comment text, carriage return) queues no request
// reset: synchronous, lexer returns to normal code, queue and result register empty
`default_nettype none

module c_comment_stripper_unit #(
  parameter int QueueDepth = 4
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        char_valid,
  output logic       char_stall,
  input  wire  [7:0] in_char,
  input  wire        end_of_stream,
  output logic       result_valid,
  input  wire        result_stall,
  output logic [7:0] out_char,
  output logic       stream_done,
  output logic       last
);
  import ccs_pkg::*;

  logic       push;
  ccs_entry_t push_entry;
  logic       queue_full;
  logic       pop;
  logic       head_valid;
  ccs_entry_t head;

  ccs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .char_valid    (char_valid),
    .char_stall    (char_stall),
    .in_char       (in_char),
    .end_of_stream (end_of_stream),
    .queue_full    (queue_full),
    .push          (push),
    .push_entry    (push_entry)
  );

  ccs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ccs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_char     (out_char),
    .stream_done  (stream_done),
    .last         (last)
  );

endmodule

`default_nettype wire

[src/ccs_checker.sv]
// port-level checks for the comment stripper, bound to the top level
`default_nettype none
`include "c_comment_stripper_unit_macros.svh"

module ccs_checker (
  input wire       clk,
  input wire       rst,
  input wire       char_valid,
  input wire       char_stall,
  input wire       end_of_stream,
  input wire       result_valid,
  input wire       result_stall,
  input wire [7:0] out_char,
  input wire       stream_done,
  input wire       last
);

  // a stalled result holds
  `CCS_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(out_char) && $stable(stream_done) && $stable(last))

  // the end marker closes its request and carries a zero byte
  `CCS_ASSERT_IMPL(a_done_last, result_valid && stream_done, last && out_char == 8'h00)

  // nothing comes out the cycle after reset
  `CCS_ASSERT_RST(a_rst_idle, rst, !result_valid)

  // an accepted end-of-stream request reaches the output when the result register is empty and no reset intervenes
  `CCS_ASSERT_IMPL(a_eos_out, $past(char_valid && !char_stall && end_of_stream, 2) && $past(!result_valid, 1) && !$past(rst, 1) && !$past(rst, 2), result_valid)

endmodule

bind c_comment_stripper_unit ccs_checker u_ccs_checker (.*);

`default_nettype wire

[sim/testbench.sv]
// self-checking testbench for the c comment stripper: directed and random source text
`timescale 1ns / 100ps

module testbench;
  import ccs_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       done;
    logic       last;
  } strip_result_t;

  // tracks the lexer mode and holds the output bytes still owed by the block
  class strip_scoreboard;
    ccs_mode_t     mode = MODE_NORMAL;
    strip_result_t expected_bytes[$];
    strip_result_t batch[$];
    int            errors = 0;

    function void emit(logic [7:0] ch, logic done);
      strip_result_t r;
      r.ch   = ch;
      r.done = done;
      r.last = 1'b0;
      batch.push_back(r);
    endfunction

    function void code_byte(logic [7:0] c);
      if (c == CH_SLASH) begin
        mode = MODE_SLASH;
      end else begin
        emit(c, 1'b0);
        if (c == CH_DQ) mode = MODE_DQ;
        else if (c == CH_SQ) mode = MODE_SQ;
        else mode = MODE_NORMAL;
      end
    endfunction

    // called once per accepted request
    function void predict_byte(logic [7:0] c, logic eos);
      logic [7:0] quote;
      batch.delete();
      if (eos) begin
        if (mode == MODE_SLASH) emit(CH_SLASH, 1'b0);
        emit(CH_NUL, 1'b1);
        mode = MODE_NORMAL;
      end else if (c != CH_CR) begin
        case (mode)
          MODE_SLASH: begin
            if (c == CH_SLASH) mode = MODE_LINE;
            else if (c == CH_STAR) mode = MODE_BLOCK;
            else begin
              emit(CH_SLASH, 1'b0);
              code_byte(c);
            end
          end
          MODE_LINE: begin
            if (c == CH_NL) begin
              emit(c, 1'b0);
              mode = MODE_NORMAL;
            end else if (c == CH_BSL) begin
              mode = MODE_LINE_BS;
            end
          end
          MODE_LINE_BS: begin
            mode = (c == CH_BSL) ? MODE_LINE_BS : MODE_LINE;
          end
          MODE_BLOCK: begin
            if (c == CH_STAR) mode = MODE_BLOCK_ST;
            else if (c == CH_NL) emit(c, 1'b0);
          end
          MODE_BLOCK_ST: begin
            if (c == CH_SLASH) mode = MODE_NORMAL;
            else if (c != CH_STAR) begin
              if (c == CH_NL) emit(c, 1'b0);
              mode = MODE_BLOCK;
            end
          end
          MODE_DQ, MODE_SQ: begin
            quote = (mode == MODE_DQ) ? CH_DQ : CH_SQ;
            emit(c, 1'b0);
            if (c == CH_BSL) mode = (mode == MODE_DQ) ? MODE_DQ_ESC : MODE_SQ_ESC;
            else if (c == quote || c == CH_NL) mode = MODE_NORMAL;
          end
          MODE_DQ_ESC: begin
            emit(c, 1'b0);
            mode = MODE_DQ;
          end
          MODE_SQ_ESC: begin
            emit(c, 1'b0);
            mode = MODE_SQ;
          end
          default: code_byte(c);
        endcase
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) expected_bytes.push_back(batch[i]);
    endfunction

    function void check_byte(logic [7:0] ch, logic done, logic lst);
      strip_result_t e;
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: out_char %02h stream_done %0b last %0b", ch, done, lst);
        errors++;
        return;
      end
      e = expected_bytes.pop_front();
      if (ch !== e.ch) begin
        $error("out_char: expected %02h, got %02h", e.ch, ch);
        errors++;
      end
      if (done !== e.done) begin
        $error("stream_done: expected %0b, got %0b", e.done, done);
        errors++;
      end
      if (lst !== e.last) begin
        $error("last: expected %0b, got %0b", e.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_stall;
  logic [7:0] in_char = 8'h00;
  logic       end_of_stream = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] out_char;
  logic       stream_done;
  logic       last;

  strip_scoreboard sb;
  int              send_idle_pct = 24;
  int              recv_stall_pct = 24;
  int              sent_count = 0;
  logic [8:0]      text_q[$];

  c_comment_stripper_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .in_char      (in_char),
    .end_of_stream(end_of_stream),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_char     (out_char),
    .stream_done  (stream_done),
    .last         (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // result side: check accepted bytes, stall at random
  initial begin
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (result_valid && !result_stall) sb.check_byte(out_char, stream_done, last);
        result_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic send_request(input logic [7:0] c, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid    <= 1'b1;
    in_char       <= c;
    end_of_stream <= eos;
    do @(posedge clk); while (char_stall);
    sb.predict_byte(c, eos);
    if (eos || c != CH_CR) sent_count++;
  endtask

  task automatic wait_drained();
    char_valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] body_char();
    case ($urandom_range(19))
      0:       return CH_SLASH;
      1:       return CH_STAR;
      2:       return CH_BSL;
      3:       return CH_NL;
      4:       return CH_DQ;
      5:       return CH_SQ;
      6:       return CH_CR;
      7:       return 8'($urandom_range(255));
      default: return 8'($urandom_range(8'h20, 8'h7E));
    endcase
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    do b = 8'($urandom_range(8'h20, 8'h7E));
    while (b == CH_SLASH || b == CH_STAR || b == CH_DQ || b == CH_SQ || b == CH_BSL);
    return b;
  endfunction

  function automatic void add(logic [7:0] c);
    text_q.push_back({1'b0, c});
  endfunction

  function automatic void add_eos();
    text_q.push_back({1'b1, 8'($urandom_range(255))});
  endfunction

  // mostly well-formed c fragments with random content, some noise and cut-off pieces
  function automatic void build_fragment();
    int n;
    n = $urandom_range(0, 10);
    case ($urandom_range(11))
      0, 1: begin
        add(CH_SLASH);
        add(CH_SLASH);
        repeat (n) begin
          if ($urandom_range(5) == 0) begin
            add(CH_BSL);
            if ($urandom_range(1)) add(CH_CR);
            add(CH_NL);
          end else begin
            add(($urandom_range(3) == 0) ? body_char() : plain_char());
          end
        end
        if ($urandom_range(1)) add(CH_CR);
        add(CH_NL);
      end
      2, 3: begin
        add(CH_SLASH);
        add(CH_STAR);
        repeat (n) add(($urandom_range(2) == 0) ? body_char() : plain_char());
        repeat ($urandom_range(1, 3)) add(CH_STAR);
        add(CH_SLASH);
      end
      4: begin
        add(CH_DQ);
        repeat (n) begin
          if ($urandom_range(4) == 0) begin
            add(CH_BSL);
            add(body_char());
          end else begin
            add(($urandom_range(3) == 0) ? body_char() : plain_char());
          end
        end
        add(($urandom_range(5) == 0) ? CH_NL : CH_DQ);
      end
      5: begin
        add(CH_SQ);
        if ($urandom_range(1)) add(CH_BSL);
        add(body_char());
        add(($urandom_range(5) == 0) ? CH_NL : CH_SQ);
      end
      6, 7, 8: begin
        repeat (n + 1) begin
          case ($urandom_range(5))
            0: begin
              add(CH_SLASH);
              add(($urandom_range(1)) ? plain_char() : CH_SLASH);
            end
            1: begin
              add(CH_CR);
              add(CH_NL);
            end
            default: add(plain_char());
          endcase
        end
      end
      9: begin
        repeat (n + 1) add(8'($urandom_range(255)));
      end
      10: begin
        // cut-off construct closed by end of stream
        case ($urandom_range(3))
          0: add(CH_SLASH);
          1: begin
            add(CH_SLASH);
            add(CH_STAR);
            add(plain_char());
          end
          2: begin
            add(CH_DQ);
            add(CH_BSL);
          end
          default: begin
            add(CH_SLASH);
            add(CH_SLASH);
            add(CH_BSL);
          end
        endcase
        add_eos();
      end
      default: add_eos();
    endcase
  endfunction

  initial begin
    logic [7:0] directed[$];
    logic [8:0] item;
    bit         paused;
    paused = 0;
    sb = new;
    // null and all-ones, held slash resolved, line comment with continuation,
    // block comment with a newline and star run, escaped newline in a char literal,
    // held slash flushed by end of stream
    directed = '{8'h00, 8'hFF, CH_SLASH, "x",
                 CH_SLASH, CH_SLASH, CH_BSL, CH_CR, CH_NL, "b", CH_NL,
                 CH_SLASH, CH_STAR, CH_STAR, CH_NL, CH_STAR, CH_SLASH,
                 CH_SQ, CH_BSL, CH_NL, CH_DQ, CH_NL,
                 CH_SLASH};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_request(directed[i], 1'b0);
    send_request(8'hA5, 1'b1);
    wait_drained();

    while (sent_count < 1600) begin
      if (sent_count >= 400 && sent_count < 800) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end else begin
        send_idle_pct  = 24;
        recv_stall_pct = 24;
      end
      if (!paused && sent_count >= 1000) begin
        paused = 1;
        wait_drained();
      end
      if (text_q.size() == 0) build_fragment();
      item = text_q.pop_front();
      send_request(item[7:0], item[8]);
    end
    send_request(8'h5A, 1'b1);
    wait_drained();
    repeat (8) @(posedge clk);

    if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
